[src/mdf_pkg.sv]
package mdf_pkg;

	localparam int unsigned Width = 30;
	localparam logic [Width-1:0] Prime = 30'd998244353;
	localparam logic [Width-1:0] Expo = 30'd998244351;
	localparam int unsigned ExpBits = Width;

	// barrett constant floor(2^60 / prime), fits in 31 bits
	localparam logic [63:0] MuFull = (64'd1 << 60) / 64'd998244353;
	localparam logic [30:0] Mu = MuFull[30:0];

	// one square per exponent bit, one multiply per set bit, one final multiply
	localparam int unsigned PowOps = ExpBits + $countones(Expo);
	localparam int unsigned NumOps = PowOps + 1;
	localparam int unsigned OpStages = 4;

	typedef struct packed {
		logic valid;
		logic err;
		logic [Width-1:0] num;
		logic [Width-1:0] den;
	} side_t;

	// bit k set: op k squares, else multiplies by the denominator (last: numerator)
	function automatic logic [NumOps-1:0] build_sched();
		logic [NumOps-1:0] s;
		int k;
		s = '0;
		k = 0;
		for (int i = ExpBits - 1; i >= 0; i--) begin
			s[k] = 1'b1;
			k++;
			if (Expo[i]) begin
				s[k] = 1'b0;
				k++;
			end
		end
		return s;
	endfunction

	localparam logic [NumOps-1:0] SquareOp = build_sched();

endpackage

[src/modular_divide_fermat.sv]
// modular division in the prime field of order 998244353
// input channel: src_valid / src_stall with numerator and denominator, each 30 bits
// output channel: dst_valid / dst_stall with quotient and range_error
// a word moves on a rising edge where valid is high and stall is low
// quotient = numerator * denominator^(p-2) mod p; zero denominator gives zero
// an input at or above p sets range_error and forces quotient to zero
// the power is a fixed chain of 58 square/multiply steps plus one final
// multiply by the numerator, each a 4-stage barrett multiplier
// throughput: one word per cycle while the pipeline is not frozen,
// set by the fully unrolled multiplier chain
// reset clears every valid bit; the pipeline then holds no words
// when dst_stall is high with a word waiting at the output, the whole
// pipeline freezes and src_stall rises; nothing is lost or repeated
// while the output slot is empty, stall is ignored and bubbles drain
module modular_divide_fermat (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      src_valid,
	output logic                      src_stall,
	input  logic [mdf_pkg::Width-1:0] numerator,
	input  logic [mdf_pkg::Width-1:0] denominator,
	output logic                      dst_valid,
	input  logic                      dst_stall,
	output logic [mdf_pkg::Width-1:0] quotient,
	output logic                      range_error
);
	import mdf_pkg::*;

	logic en;
	logic [Width-1:0] acc [NumOps+1];
	side_t side [NumOps+1];

	assign en = !(side[NumOps].valid && dst_stall);
	assign src_stall = !en;

	assign acc[0] = Width'(1);
	assign side[0].valid = src_valid;
	assign side[0].err = (numerator >= Prime) || (denominator >= Prime);
	assign side[0].num = numerator;
	assign side[0].den = denominator;

	for (genvar j = 0; j < NumOps; j++) begin : g_op
		logic [Width-1:0] b_op;
		if (j == NumOps - 1) begin : g_last
			assign b_op = side[j].num;
		end else if (SquareOp[j]) begin : g_sq
			assign b_op = acc[j];
		end else begin : g_mul
			assign b_op = side[j].den;
		end
		mdf_mulmod u_mulmod (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.a        (acc[j]),
			.b        (b_op),
			.side     (side[j]),
			.r        (acc[j+1]),
			.side_dly (side[j+1])
		);
	end

	assign dst_valid = side[NumOps].valid;
	assign range_error = side[NumOps].err;
	assign quotient = side[NumOps].err ? '0 : acc[NumOps];

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && range_error |-> quotient == '0)
		else $error("range error word with nonzero quotient");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !range_error |-> quotient < Prime)
		else $error("quotient not reduced");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid && dst_stall)
		else $error("input stalled without output backpressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |=> dst_valid)
		else $error("output word lost during freeze");

endmodule

[src/mdf_mulmod.sv]
module mdf_mulmod (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [mdf_pkg::Width-1:0] a,
	input  logic [mdf_pkg::Width-1:0] b,
	input  mdf_pkg::side_t          side,
	output logic [mdf_pkg::Width-1:0] r,
	output mdf_pkg::side_t          side_dly
);
	import mdf_pkg::*;

	logic [2*Width-1:0] x_s1;
	side_t side_s1;
	logic [61:0] t_s2;
	logic [31:0] xl_s2;
	side_t side_s2;
	logic [31:0] qp_s3;
	logic [31:0] xl_s3;
	side_t side_s3;
	logic [Width-1:0] r_s4;
	side_t side_s4;

	logic [30:0] q;
	logic [32:0] d0;
	logic [32:0] d1;
	logic [32:0] d2;

	assign q = t_s2[61:31];
	assign d0 = {1'b0, xl_s3 - qp_s3};
	assign d1 = d0 - 33'(Prime);
	assign d2 = d0 - 33'({Prime, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.valid <= 1'b0;
			side_s2.valid <= 1'b0;
			side_s3.valid <= 1'b0;
			side_s4.valid <= 1'b0;
		end else if (en) begin
			x_s1 <= (2*Width)'(a) * (2*Width)'(b);
			side_s1 <= side;
			t_s2 <= 62'(x_s1[59:29]) * 62'(Mu);
			xl_s2 <= x_s1[31:0];
			side_s2 <= side_s1;
			qp_s3 <= 32'(q) * 32'(Prime);
			xl_s3 <= xl_s2;
			side_s3 <= side_s2;
			if (!d2[32]) begin
				r_s4 <= d2[Width-1:0];
			end else if (!d1[32]) begin
				r_s4 <= d1[Width-1:0];
			end else begin
				r_s4 <= d0[Width-1:0];
			end
			side_s4 <= side_s3;
		end
	end

	assign r = r_s4;
	assign side_dly = side_s4;

endmodule
